@@ design/assert_macros.svh @@
// assertion helpers, clocked on clock and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/asdz_pkg.sv @@
package asdz_pkg;
   localparam int ZONE_W = 15;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int POWER_W = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_ZONE_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ZONE_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ZONE_SHAPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SQUIRCLE_POWER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIAL_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIAL_Y = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIAL_MODE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIGGER_MODE = 3'd7;

   localparam logic [1:0] SHAPE_ELLIPSE = 2'd0;
   localparam logic [1:0] SHAPE_SQUIRCLE = 2'd1;
   localparam logic [1:0] SHAPE_DIAMOND = 2'd2;
   localparam logic [1:0] SHAPE_SQUARE = 2'd3;

   localparam logic [ZONE_W-1:0] ZONE_RESET = 15'd9830;
   localparam logic [POWER_W-1:0] POWER_RESET = 4'd3;
endpackage

@@ design/asdz_if.sv @@
interface asdz_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] stick_x;
   logic signed [SAMPLE_BITS-1:0] stick_y;

   modport source (output valid, output stick_x, output stick_y, input ready);
   modport sink (input valid, input stick_x, input stick_y, output ready);
endinterface

interface asdz_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_x;
   logic signed [SAMPLE_BITS-1:0] out_y;
   logic                          radial_pass;

   modport source (output valid, output out_x, output out_y, output radial_pass,
                   input ready);
   modport sink (input valid, input out_x, input out_y, input radial_pass,
                 output ready);
endinterface

@@ design/analog_stick_dead_zone.sv @@
// Dead zone for one analog stick: each request carries a signed x/y sample and
// gives one response with the filtered sample and a radial pass flag. The block
// is a single pipeline that takes one request per cycle unless the response
// stalls; its depth is set by the squircle path, a divider retiring four
// quotient bits per stage followed by one Q1.F multiplier stage per power
// step. A stalled response freezes the whole pipeline. Registers may be
// written only while no request is in flight.
`include "assert_macros.svh"

module analog_stick_dead_zone import asdz_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRACTION_BITS = 16,
   parameter int MAX_POWER = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   asdz_req_if.sink               req_bus,
   asdz_rsp_if.source             rsp_bus,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);
   localparam int SB = SAMPLE_BITS;
   localparam int F = FRACTION_BITS;
   localparam int MW = (SB > ZONE_W) ? SB : ZONE_W;
   localparam int DIV_STEP = 4;
   localparam int DIV_ST = (F + DIV_STEP - 1) / DIV_STEP;
   localparam int LAST = DIV_ST + MAX_POWER;
   localparam int PCW0 = $clog2(MAX_POWER + 1);
   localparam int PCW = (PCW0 > POWER_W) ? PCW0 : POWER_W;
   localparam int PW = 2 * ZONE_W;
   localparam int SW = 2 * PW;
   localparam logic [F:0] Q_ONE = (F + 1)'(1) << F;

   typedef struct packed {
      logic [SB-1:0]     x;
      logic [SB-1:0]     y;
      logic [MW-1:0]     ax;
      logic [MW-1:0]     ay;
      logic              outside;
      logic              sat_x;
      logic              sat_y;
      logic [ZONE_W-1:0] rem_x;
      logic [ZONE_W-1:0] rem_y;
      logic [F:0]        q_x;
      logic [F:0]        q_y;
      logic [F:0]        pw_x;
      logic [F:0]        pw_y;
      logic [PW-1:0]     p_xy;
      logic [PW-1:0]     p_yx;
      logic [PW-1:0]     p_dd;
      logic [SW-1:0]     s_x;
      logic [SW-1:0]     s_y;
      logic [SW-1:0]     s_d;
      logic              dia_lt;
      logic              ell_lt;
   } pipe_type;

   logic [ZONE_W-1:0]  zone_x_ff, zone_y_ff, axial_x_ff, axial_y_ff;
   logic [1:0]         shape_ff;
   logic [POWER_W-1:0] power_ff;
   logic               axial_mode_ff, trigger_mode_ff;

   pipe_type           st_ff [LAST+1];
   logic [LAST:0]      vld_ff;
   pipe_type           nxt [LAST];
   pipe_type           st0_in;

   logic [SB-1:0]      out_x_ff, out_y_ff;
   logic               pass_ff, out_valid_ff;
   logic [SB-1:0]      out_x_in, out_y_in;
   logic               pass_in;

   logic               advance;
   logic [PCW-1:0]     power_eff;
   logic [MW-1:0]      zx_w, zy_w, axx_w, axy_w;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign zx_w = MW'(zone_x_ff);
   assign zy_w = MW'(zone_y_ff);
   assign axx_w = MW'(axial_x_ff);
   assign axy_w = MW'(axial_y_ff);
   assign power_eff = (PCW'(power_ff) > PCW'(MAX_POWER)) ? PCW'(MAX_POWER) : PCW'(power_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_x_ff <= ZONE_RESET;
         zone_y_ff <= ZONE_RESET;
         shape_ff <= SHAPE_ELLIPSE;
         power_ff <= POWER_RESET;
         axial_x_ff <= ZONE_RESET;
         axial_y_ff <= ZONE_RESET;
         axial_mode_ff <= 1'b0;
         trigger_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ZONE_X: zone_x_ff <= csr_data[ZONE_W-1:0];
            REG_ZONE_Y: zone_y_ff <= csr_data[ZONE_W-1:0];
            REG_ZONE_SHAPE: shape_ff <= csr_data[1:0];
            REG_SQUIRCLE_POWER: power_ff <= csr_data[POWER_W-1:0];
            REG_AXIAL_X: axial_x_ff <= csr_data[ZONE_W-1:0];
            REG_AXIAL_Y: axial_y_ff <= csr_data[ZONE_W-1:0];
            REG_AXIAL_MODE: axial_mode_ff <= csr_data[0];
            REG_TRIGGER_MODE: trigger_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // magnitudes and squircle saturation
   always_comb begin
      logic [SB-1:0] sx, sy;
      sx = req_bus.stick_x;
      sy = req_bus.stick_y;
      st0_in = '0;
      st0_in.x = sx;
      st0_in.y = sy;
      st0_in.ax = MW'(sx[SB-1] ? (~sx + SB'(1)) : sx);
      st0_in.ay = MW'(sy[SB-1] ? (~sy + SB'(1)) : sy);
      st0_in.outside = (st0_in.ax >= zx_w) || (st0_in.ay >= zy_w);
      st0_in.sat_x = (zone_x_ff == '0) || (st0_in.ax >= zx_w);
      st0_in.sat_y = (zone_y_ff == '0) || (st0_in.ay >= zy_w);
      st0_in.rem_x = st0_in.sat_x ? '0 : st0_in.ax[ZONE_W-1:0];
      st0_in.rem_y = st0_in.sat_y ? '0 : st0_in.ay[ZONE_W-1:0];
      st0_in.pw_x = Q_ONE;
      st0_in.pw_y = Q_ONE;
   end

   for (genvar t = 0; t < LAST; t++) begin : g_stage
      always_comb begin
         logic [ZONE_W:0]     r2x, r2y;
         logic [F:0]          ux, uy;
         logic [2*F+1:0]      mx, my;
         logic [PW:0]         dsum;
         logic [SW:0]         esum;
         nxt[t] = st_ff[t];
         r2x = '0;
         r2y = '0;
         ux = '0;
         uy = '0;
         mx = '0;
         my = '0;
         dsum = '0;
         esum = '0;
         if (t == 0) begin
            nxt[t].p_xy = PW'(st_ff[t].ax[ZONE_W-1:0]) * PW'(zone_y_ff);
            nxt[t].p_yx = PW'(st_ff[t].ay[ZONE_W-1:0]) * PW'(zone_x_ff);
            nxt[t].p_dd = PW'(zone_x_ff) * PW'(zone_y_ff);
         end
         if (t == 1) begin
            nxt[t].s_x = SW'(st_ff[t].p_xy) * SW'(st_ff[t].p_xy);
            nxt[t].s_y = SW'(st_ff[t].p_yx) * SW'(st_ff[t].p_yx);
            nxt[t].s_d = SW'(st_ff[t].p_dd) * SW'(st_ff[t].p_dd);
            dsum = (PW + 1)'(st_ff[t].p_xy) + (PW + 1)'(st_ff[t].p_yx);
            nxt[t].dia_lt = dsum < (PW + 1)'(st_ff[t].p_dd);
         end
         if (t == 2) begin
            esum = (SW + 1)'(st_ff[t].s_x) + (SW + 1)'(st_ff[t].s_y);
            nxt[t].ell_lt = esum < (SW + 1)'(st_ff[t].s_d);
         end
         if (t < DIV_ST) begin
            for (int j = 0; j < DIV_STEP; j++) begin
               if (t * DIV_STEP + j < F) begin
                  r2x = {nxt[t].rem_x, 1'b0};
                  r2y = {nxt[t].rem_y, 1'b0};
                  if (r2x >= {1'b0, zone_x_ff}) begin
                     nxt[t].rem_x = ZONE_W'(r2x - {1'b0, zone_x_ff});
                     nxt[t].q_x = {nxt[t].q_x[F-1:0], 1'b1};
                  end else begin
                     nxt[t].rem_x = r2x[ZONE_W-1:0];
                     nxt[t].q_x = {nxt[t].q_x[F-1:0], 1'b0};
                  end
                  if (r2y >= {1'b0, zone_y_ff}) begin
                     nxt[t].rem_y = ZONE_W'(r2y - {1'b0, zone_y_ff});
                     nxt[t].q_y = {nxt[t].q_y[F-1:0], 1'b1};
                  end else begin
                     nxt[t].rem_y = r2y[ZONE_W-1:0];
                     nxt[t].q_y = {nxt[t].q_y[F-1:0], 1'b0};
                  end
               end
            end
         end else begin
            ux = st_ff[t].sat_x ? Q_ONE : st_ff[t].q_x;
            uy = st_ff[t].sat_y ? Q_ONE : st_ff[t].q_y;
            mx = (2 * F + 2)'(st_ff[t].pw_x) * (2 * F + 2)'(ux);
            my = (2 * F + 2)'(st_ff[t].pw_y) * (2 * F + 2)'(uy);
            if (PCW'(t - DIV_ST) < power_eff) begin
               nxt[t].pw_x = mx[2*F:F];
               nxt[t].pw_y = my[2*F:F];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAST-1:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= st0_in;
         for (int k = 0; k < LAST; k++) begin
            st_ff[k+1] <= nxt[k];
         end
      end
   end

   // shape decision, trigger and axial stages
   always_comb begin
      pipe_type      s;
      logic          radial;
      logic [F+1:0]  qsum;
      s = st_ff[LAST];
      qsum = (F + 2)'(s.pw_x) + (F + 2)'(s.pw_y);
      case (shape_ff)
         SHAPE_ELLIPSE: radial = s.outside || !s.ell_lt;
         SHAPE_SQUIRCLE: radial = qsum >= (F + 2)'(Q_ONE);
         SHAPE_DIAMOND: radial = s.outside || !s.dia_lt;
         default: radial = s.outside;
      endcase
      if (trigger_mode_ff) begin
         out_x_in = (s.ax > zx_w) ? s.x : '0;
         out_y_in = (s.ay > zy_w) ? s.y : '0;
         pass_in = 1'b0;
      end else if (!radial) begin
         out_x_in = '0;
         out_y_in = '0;
         pass_in = 1'b0;
      end else begin
         out_x_in = (!axial_mode_ff && (s.ax < axx_w)) ? '0 : s.x;
         out_y_in = (!axial_mode_ff && (s.ay < axy_w)) ? '0 : s.y;
         pass_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         pass_ff <= pass_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.out_x = out_x_ff;
   assign rsp_bus.out_y = out_y_ff;
   assign rsp_bus.radial_pass = pass_ff;

   `ASSERT_SAME(a_trigger_no_pass, rsp_bus.valid && trigger_mode_ff, !rsp_bus.radial_pass)
   `ASSERT_SAME(a_inside_zero, rsp_bus.valid && !trigger_mode_ff && !rsp_bus.radial_pass, (rsp_bus.out_x == '0) && (rsp_bus.out_y == '0))
   `ASSERT_NEXT(a_req_enters, req_bus.valid && req_bus.ready, vld_ff[0])
endmodule

@@ test/analog_stick_dead_zone_test.sv @@
module analog_stick_dead_zone_test;
   import asdz_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 14;
   localparam int RANDOM_ITEMS = 1600;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } stick_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               pass;
   } filtered_type;

   typedef struct {
      stick_type    stick;
      bit           typed;
      filtered_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_ZONE_X;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   asdz_req_if #(.SAMPLE_BITS(16)) req_bus ();
   asdz_rsp_if #(.SAMPLE_BITS(16)) rsp_bus ();

   analog_stick_dead_zone dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   logic [14:0] zone_x_q, zone_y_q, axial_x_q, axial_y_q;
   logic [1:0]  shape_q;
   logic [3:0]  power_q;
   logic        axial_off_q, trigger_q;

   filtered_type expected_q[$];
   int mismatches = 0;
   int samples_sent = 0;
   int samples_checked = 0;
   int settings_run = 0;
   bit quiet = 1'b0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.stick_x = '0;
      req_bus.stick_y = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic logic [16:0] stick_magnitude(logic signed [15:0] v);
      logic [16:0] m;
      m = v[15] ? 17'(-$signed(17'(v))) : 17'(v);
      return m;
   endfunction

   function automatic logic [16:0] unit_norm(logic [16:0] a, logic [14:0] d);
      logic [63:0] u;
      if (d == 0 || a >= d) return 17'h10000;
      u = (64'(a) << 16) / d;
      return u > 64'h10000 ? 17'h10000 : 17'(u);
   endfunction

   function automatic logic [16:0] unit_power(logic [16:0] u, int p);
      logic [63:0] r;
      r = 64'h10000;
      for (int i = 0; i < p; i++) r = (r * u) >> 16;
      return 17'(r);
   endfunction

   function automatic bit outside_radial(logic [16:0] ax, logic [16:0] ay);
      logic [127:0] dx, dy, mx, my;
      dx = zone_x_q;
      dy = zone_y_q;
      mx = ax;
      my = ay;
      case (shape_q)
         SHAPE_ELLIPSE: begin
            if (mx >= dx || my >= dy) return 1'b1;
            return !(mx*mx*dy*dy + my*my*dx*dx < dx*dx*dy*dy);
         end
         SHAPE_SQUIRCLE: begin
            int p;
            p = power_q > 8 ? 8 : power_q;
            return !(18'(unit_power(unit_norm(ax, zone_x_q), p))
                     + 18'(unit_power(unit_norm(ay, zone_y_q), p)) < 18'h10000);
         end
         SHAPE_DIAMOND: begin
            if (mx >= dx || my >= dy) return 1'b1;
            return !(mx*dy + my*dx < dx*dy);
         end
         default: return mx >= dx || my >= dy;
      endcase
   endfunction

   function automatic filtered_type dead_zone(stick_type s);
      filtered_type r;
      logic [16:0] ax, ay;
      ax = stick_magnitude(s.x);
      ay = stick_magnitude(s.y);
      r = '0;
      if (trigger_q) begin
         r.x = ax > zone_x_q ? s.x : '0;
         r.y = ay > zone_y_q ? s.y : '0;
      end else if (outside_radial(ax, ay)) begin
         r.pass = 1'b1;
         r.x = (!axial_off_q && ax < axial_x_q) ? '0 : s.x;
         r.y = (!axial_off_q && ay < axial_y_q) ? '0 : s.y;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, filtered_type got, filtered_type want);
      $display("mismatch %s at %0t: got x=%0d y=%0d pass=%0b, want x=%0d y=%0d pass=%0b",
               what, $realtime, got.x, got.y, got.pass, want.x, want.y, want.pass);
      mismatches++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         REG_ZONE_X: zone_x_q = data;
         REG_ZONE_Y: zone_y_q = data;
         REG_ZONE_SHAPE: shape_q = data[1:0];
         REG_SQUIRCLE_POWER: power_q = data[3:0];
         REG_AXIAL_X: axial_x_q = data;
         REG_AXIAL_Y: axial_y_q = data;
         REG_AXIAL_MODE: axial_off_q = data[0];
         default: trigger_q = data[0];
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   // called at a falling edge; valid stays high so requests can follow back to back
   task automatic send_request(stick_type s, bit typed, filtered_type want);
      filtered_type p;
      p = dead_zone(s);
      if (typed && p != want) report_mismatch("typed row", p, want);
      while (!quiet && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.stick_x <= s.x;
      req_bus.stick_y <= s.y;
      expected_q.push_back(typed ? want : p);
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] random_axis();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(30000)) - 16'sd15000;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= quiet || $urandom_range(99) >= 9;
   end

   always @(posedge clock) begin
      filtered_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_x, rsp_bus.out_y, rsp_bus.radial_pass};
         if (expected_q.size() == 0) report_mismatch("unexpected response", got, '0);
         else begin
            if (got != expected_q[0]) report_mismatch("response", got, expected_q[0]);
            void'(expected_q.pop_front());
            samples_checked++;
         end
      end
   end

   initial begin
      #30ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      directed_row_type rows[$];
      stick_type s;
      int items;
      zone_x_q = ZONE_RESET;
      zone_y_q = ZONE_RESET;
      axial_x_q = ZONE_RESET;
      axial_y_q = ZONE_RESET;
      shape_q = SHAPE_ELLIPSE;
      power_q = POWER_RESET;
      axial_off_q = 1'b0;
      trigger_q = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows = '{
         '{'{16'sd0, 16'sd0}, 1, '{16'sd0, 16'sd0, 1'b0}},
         '{'{16'sh7fff, 16'sd0}, 1, '{16'sh7fff, 16'sd0, 1'b1}},
         '{'{16'sh8000, 16'sh8000}, 1, '{16'sh8000, 16'sh8000, 1'b1}},
         '{'{16'sd9830, 16'sd0}, 1, '{16'sd9830, 16'sd0, 1'b1}},
         '{'{16'sd9829, 16'sd0}, 1, '{16'sd0, 16'sd0, 1'b0}},
         '{'{-16'sd9830, 16'sd100}, 1, '{-16'sd9830, 16'sd0, 1'b1}},
         '{'{16'sd7000, 16'sd7000}, 0, '0},
         '{'{16'sd6900, -16'sd6960}, 0, '0},
         '{'{16'sh8000, 16'sh7fff}, 1, '{16'sh8000, 16'sh7fff, 1'b1}},
         '{'{-16'sd1, 16'sd1}, 1, '{16'sd0, 16'sd0, 1'b0}}
      };
      for (int shape = 0; shape < 4; shape++) begin
         write_reg(REG_ZONE_SHAPE, CSR_DATA_W'(shape));
         foreach (rows[i]) send_request(rows[i].stick, rows[i].typed, rows[i].want);
         drain();
         settings_run++;
      end

      write_reg(REG_ZONE_SHAPE, CSR_DATA_W'(SHAPE_SQUIRCLE));
      foreach (rows[i]) begin
         write_reg(REG_SQUIRCLE_POWER, CSR_DATA_W'(i % 2 ? 15 : 0));
         send_request(rows[i].stick, 0, '0);
         drain();
      end
      write_reg(REG_ZONE_X, '0);
      write_reg(REG_TRIGGER_MODE, 15'd1);
      foreach (rows[i]) send_request(rows[i].stick, 0, '0);
      drain();
      write_reg(REG_TRIGGER_MODE, '0);
      write_reg(REG_AXIAL_MODE, 15'd1);
      foreach (rows[i]) send_request(rows[i].stick, 0, '0);
      drain();
      settings_run += 3;

      items = 0;
      while (items < RANDOM_ITEMS) begin
         case ($urandom_range(3))
            0: begin
               write_reg(REG_ZONE_X, 15'h7fff);
               write_reg(REG_ZONE_Y, 15'h7fff);
               write_reg(REG_AXIAL_X, 15'h7fff);
               write_reg(REG_AXIAL_Y, '0);
            end
            default: begin
               write_reg(REG_ZONE_X, $urandom_range(3) == 0 ? '0 : 15'($urandom));
               write_reg(REG_ZONE_Y, $urandom_range(3) == 0 ? '0 : 15'($urandom));
               write_reg(REG_AXIAL_X, 15'($urandom));
               write_reg(REG_AXIAL_Y, 15'($urandom_range(20000)));
            end
         endcase
         write_reg(REG_ZONE_SHAPE, 15'($urandom_range(3)));
         write_reg(REG_SQUIRCLE_POWER, 15'($urandom_range(15)));
         write_reg(REG_AXIAL_MODE, 15'($urandom_range(1)));
         write_reg(REG_TRIGGER_MODE, 15'($urandom_range(3) == 0));
         quiet = (settings_run % 5) == 2;
         for (int k = 0; k < 100; k++) begin
            s.x = random_axis();
            s.y = random_axis();
            if (k < 40) begin
               s.x = 16'(16'($signed(16'($urandom_range(zone_x_q + 200))) - 16'sd100)
                         * ($urandom_range(1) ? 1 : -1));
               s.y = 16'($signed(16'($urandom_range(zone_y_q + 200))) - 16'sd100);
            end
            send_request(s, 0, '0);
            items++;
         end
         drain();
         settings_run++;
      end
      quiet = 1'b0;
      drain();

      $display("sent %0d samples, checked %0d responses over %0d register settings",
               samples_sent, samples_checked, settings_run);
      $display("covered all four shapes, trigger mode, axial stage on and off");
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+design
design/asdz_pkg.sv
design/asdz_if.sv
design/analog_stick_dead_zone.sv
test/analog_stick_dead_zone_test.sv
